[hw/rtl/ksct_pkg.sv]
// Package for the scan-code set 1 keyboard translator: beat structs, scan and
// command codes, the two layout tables and the queue entry encoding.
// No dependencies.
package ksct_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int TOKQ_DEPTH = 2;
	localparam int APB_AW = 3;
	localparam int ENTRY_W = 4;

	localparam logic [0:0] REG_LED_INIT = 1'b0;
	localparam logic CMD_SCAN = 1'b0;

	localparam logic [7:0] SC_BKSP = 8'h0E;
	localparam logic [7:0] SC_TAB = 8'h0F;
	localparam logic [7:0] SC_ENTER = 8'h1C;
	localparam logic [7:0] SC_LSHIFT_MK = 8'h2A;
	localparam logic [7:0] SC_RSHIFT_MK = 8'h36;
	localparam logic [7:0] SC_CAPS = 8'h3A;
	localparam logic [7:0] SC_F1 = 8'h3B;
	localparam logic [7:0] SC_NUM = 8'h45;
	localparam logic [7:0] SC_SCROLL = 8'h46;
	localparam logic [7:0] SC_F11 = 8'h57;
	localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
	localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;
	localparam logic [7:0] KBD_SET_LEDS = 8'hED;
	localparam logic [7:0] KBD_ACK = 8'hFA;
	localparam logic [7:0] KBD_RESEND = 8'hFE;

	localparam logic [2:0] LED_SCROLL = 3'b001;
	localparam logic [2:0] LED_NUM = 3'b010;
	localparam logic [2:0] LED_CAPS = 3'b100;

	// Queue entries hold either the LED command or a 3-bit LED value.
	localparam logic [ENTRY_W-1:0] ENTRY_ED = 4'b1000;

	typedef enum logic [2:0] {
		SK_NONE      = 3'd0,
		SK_BACKSPACE = 3'd1,
		SK_ENTER     = 3'd2,
		SK_TAB       = 3'd3,
		SK_SHIFT_F1  = 3'd4,
		SK_F11       = 3'd5
	} special_t;

	typedef enum logic [1:0] {
		SEND_NONE,
		SEND_RESEND,
		SEND_POP_RAM,
		SEND_POP_ED
	} send_kind_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] scan_byte;
	} item_t;

	typedef struct packed {
		logic [6:0] char_code;
		logic       char_valid;
		logic [2:0] special_key;
		logic [7:0] kbd_send_byte;
		logic       kbd_send_valid;
		logic [2:0] led_state;
		logic       queue_overflow;
	} result_t;

	typedef struct packed {
		logic [6:0]         char_code;
		logic               char_valid;
		special_t           special_key;
		logic [2:0]         led_state;
		logic               queue_overflow;
		send_kind_t         kind;
		logic [ENTRY_W-1:0] entry;
	} tok_t;

	localparam logic [6:0] PLAIN_MAP [0:127] = '{
		7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
		7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h5E, 7'h00, 7'h00,
		7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
		7'h4F, 7'h50, 7'h40, 7'h5B, 7'h00, 7'h00, 7'h41, 7'h53,
		7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3B,
		7'h3A, 7'h00, 7'h00, 7'h5D, 7'h5A, 7'h58, 7'h43, 7'h56,
		7'h42, 7'h4E, 7'h4D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
		7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
		7'h32, 7'h33, 7'h30, 7'h2E, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h5C, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h5C, 7'h00, 7'h00
	};

	localparam logic [6:0] SHIFT_MAP [0:127] = '{
		7'h00, 7'h00, 7'h21, 7'h22, 7'h23, 7'h24, 7'h25, 7'h26,
		7'h27, 7'h28, 7'h29, 7'h7E, 7'h3D, 7'h7E, 7'h00, 7'h00,
		7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
		7'h4F, 7'h50, 7'h60, 7'h7B, 7'h00, 7'h00, 7'h41, 7'h53,
		7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h2B,
		7'h2A, 7'h00, 7'h00, 7'h7D, 7'h5A, 7'h58, 7'h43, 7'h56,
		7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
		7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
		7'h32, 7'h33, 7'h30, 7'h2E, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h5F, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h7C, 7'h00, 7'h00
	};

endpackage

[hw/rtl/keyboard_scancode_translator_core.sv]
// A result beat passes through the front token register, the back token queue and the result register.
// Throughput: one item per cycle while item_stall is low, set by the decode and queue update.
// The LED command queue sits in two RAM banks so that both bytes of a lock key
// are written in the same cycle. After reset and after each led_init write the block
// loads the two start-up LED command bytes, with item_stall high.
// Reset clears all control state but init_pend, which it sets, and sets led_init to zero.
module keyboard_scancode_translator_core #(
	parameter int QUEUE_DEPTH = ksct_pkg::QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  ksct_pkg::item_t             item,
	output logic                        result_valid,
	input  logic                        result_stall,
	output ksct_pkg::result_t           result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ksct_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic           led_init_q;
	logic [2:0]     led_init_r_q;
	logic           reg_hit;
	logic           cfg_wr;
	ksct_pkg::tok_t tok;
	logic           tok_valid;
	logic           tok_room;
	logic           init_pend;
	logic [CW-1:0]  qcount;

	assign pready = 1'b1;
	assign reg_hit = (paddr[ksct_pkg::APB_AW-1:2] == ksct_pkg::REG_LED_INIT);
	assign cfg_wr = psel && penable && pwrite && pready && reg_hit;
	assign prdata = reg_hit ? {29'd0, led_init_r_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_init_r_q <= 3'b000;
			led_init_q <= 1'b0;
		end else begin
			led_init_q <= cfg_wr;
			if (cfg_wr) begin
				led_init_r_q <= pwdata[2:0];
			end
		end
	end

	ksct_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item      (item),
		.cfg_wr    (cfg_wr),
		.cfg_led   (pwdata[2:0]),
		.tok       (tok),
		.tok_valid (tok_valid),
		.tok_room  (tok_room),
		.init_pend (init_pend),
		.qcount    (qcount)
	);

	ksct_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.tok         (tok),
		.tok_valid   (tok_valid),
		.tok_room    (tok_room),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	a_cfg_loads_queue: assert property (@(posedge clk) disable iff (!arst_n)
		led_init_q |-> init_pend)
		else $error("led_init write did not start the queue load");

	a_no_beat_during_load: assert property (@(posedge clk) disable iff (!arst_n)
		init_pend |-> item_stall)
		else $error("item beat accepted while the queue is loading");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qcount <= CW'(QUEUE_DEPTH))
		else $error("LED command queue count beyond its depth");

endmodule

[hw/rtl/ksct_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ksct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hw/rtl/ksct_front.sv]
// Front part: accepts beats, decodes scan codes, keeps shift and lock state and
// runs the LED command queue bookkeeping over two banked RAMs.
// Depends on ksct_pkg and ksct_ram.
module ksct_front #(
	parameter int QUEUE_DEPTH = ksct_pkg::QUEUE_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  ksct_pkg::item_t                    item,
	input  logic                               cfg_wr,
	input  logic [2:0]                         cfg_led,
	output ksct_pkg::tok_t                     tok,
	output logic                               tok_valid,
	input  logic                               tok_room,
	output logic                               init_pend,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]   qcount
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int BANK_DEPTH = 2 ** (AW - 1);

	logic [1:0]    shift_q;
	logic [2:0]    leds_q;
	logic          ov_q;
	logic          init_pend_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [CW-1:0] count_q;

	ksct_pkg::tok_t tok_s1;
	logic           tok_v_s1;
	logic           bank_s1;

	logic                         accept;
	logic                         scan;
	logic [7:0]                   b;
	logic [6:0]                   ch;
	ksct_pkg::special_t           sk;
	logic [1:0]                   shift_n;
	logic [2:0]                   toggle;
	logic [2:0]                   leds_n;
	logic                         push_req;
	logic                         ok0;
	logic                         ok1;
	logic                         resend;
	logic                         ack;
	logic                         pop;
	logic [CW-1:0]                count_push;
	logic [AW-1:0]                slot1;
	ksct_pkg::send_kind_t         kind;

	logic                                ev_we;
	logic                                od_we;
	logic [AW-2:0]                       ev_wa;
	logic [AW-2:0]                       od_wa;
	logic [ksct_pkg::ENTRY_W-1:0]        ev_wd;
	logic [ksct_pkg::ENTRY_W-1:0]        od_wd;
	logic [ksct_pkg::ENTRY_W-1:0]        ev_rd;
	logic [ksct_pkg::ENTRY_W-1:0]        od_rd;

	assign item_stall = init_pend_q || (tok_v_s1 && !tok_room);
	assign accept = item_valid && !item_stall;
	assign scan = accept && (item.cmd == ksct_pkg::CMD_SCAN);
	assign b = item.scan_byte;

	always_comb begin
		ch = 7'h00;
		if (scan && !b[7]) begin
			ch = (shift_q != 2'b00) ? ksct_pkg::SHIFT_MAP[b[6:0]] : ksct_pkg::PLAIN_MAP[b[6:0]];
			if ((ch inside {[7'h41:7'h5A]}) && (leds_q[2] == (shift_q != 2'b00))) begin
				ch = ch + 7'h20;
			end
		end
	end

	always_comb begin
		sk = ksct_pkg::SK_NONE;
		shift_n = shift_q;
		toggle = 3'b000;
		if (scan) begin
			case (b)
				ksct_pkg::SC_BKSP: sk = ksct_pkg::SK_BACKSPACE;
				ksct_pkg::SC_ENTER: sk = ksct_pkg::SK_ENTER;
				ksct_pkg::SC_TAB: sk = ksct_pkg::SK_TAB;
				ksct_pkg::SC_F1: begin
					if (shift_q != 2'b00) begin
						sk = ksct_pkg::SK_SHIFT_F1;
					end
				end
				ksct_pkg::SC_F11: sk = ksct_pkg::SK_F11;
				ksct_pkg::SC_LSHIFT_MK: shift_n = shift_q | 2'b01;
				ksct_pkg::SC_RSHIFT_MK: shift_n = shift_q | 2'b10;
				ksct_pkg::SC_LSHIFT_BRK: shift_n = shift_q & 2'b10;
				ksct_pkg::SC_RSHIFT_BRK: shift_n = shift_q & 2'b01;
				ksct_pkg::SC_CAPS: toggle = ksct_pkg::LED_CAPS;
				ksct_pkg::SC_NUM: toggle = ksct_pkg::LED_NUM;
				ksct_pkg::SC_SCROLL: toggle = ksct_pkg::LED_SCROLL;
				default: ;
			endcase
		end
	end

	assign leds_n = leds_q ^ toggle;
	assign push_req = init_pend_q || (toggle != 3'b000);
	assign ok0 = push_req && (count_q < CW'(QUEUE_DEPTH));
	assign ok1 = push_req && ((count_q + CW'(ok0)) < CW'(QUEUE_DEPTH));
	assign count_push = count_q + CW'(ok0) + CW'(ok1);

	assign ack = scan && (b == ksct_pkg::KBD_ACK);
	assign resend = scan && (b == ksct_pkg::KBD_RESEND) && ov_q;
	assign pop = accept && !resend && (!ov_q || ack) && (count_push != '0);

	always_comb begin
		if (resend) begin
			kind = ksct_pkg::SEND_RESEND;
		end else if (pop && (count_q == '0)) begin
			kind = ksct_pkg::SEND_POP_ED;
		end else if (pop) begin
			kind = ksct_pkg::SEND_POP_RAM;
		end else begin
			kind = ksct_pkg::SEND_NONE;
		end
	end

	assign slot1 = tail_q + AW'(1);

	always_comb begin
		if (!tail_q[0]) begin
			ev_we = ok0;
			ev_wa = tail_q[AW-1:1];
			ev_wd = ksct_pkg::ENTRY_ED;
			od_we = ok1;
			od_wa = tail_q[AW-1:1];
			od_wd = {1'b0, leds_n};
		end else begin
			od_we = ok0;
			od_wa = tail_q[AW-1:1];
			od_wd = ksct_pkg::ENTRY_ED;
			ev_we = ok1;
			ev_wa = slot1[AW-1:1];
			ev_wd = {1'b0, leds_n};
		end
	end

	ksct_ram #(
		.WIDTH(ksct_pkg::ENTRY_W),
		.DEPTH(BANK_DEPTH)
	) u_bank_even (
		.clk  (clk),
		.we   (ev_we),
		.waddr(ev_wa),
		.wdata(ev_wd),
		.re   (pop),
		.raddr(head_q[AW-1:1]),
		.rdata(ev_rd)
	);

	ksct_ram #(
		.WIDTH(ksct_pkg::ENTRY_W),
		.DEPTH(BANK_DEPTH)
	) u_bank_odd (
		.clk  (clk),
		.we   (od_we),
		.waddr(od_wa),
		.wdata(od_wd),
		.re   (pop),
		.raddr(head_q[AW-1:1]),
		.rdata(od_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 2'b00;
			leds_q <= 3'b000;
			ov_q <= 1'b0;
			init_pend_q <= 1'b1;
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
		end else if (cfg_wr) begin
			leds_q <= cfg_led;
			ov_q <= 1'b0;
			init_pend_q <= 1'b1;
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
		end else begin
			init_pend_q <= 1'b0;
			tail_q <= tail_q + AW'(ok0) + AW'(ok1);
			count_q <= count_push - CW'(pop);
			head_q <= head_q + AW'(pop);
			if (accept) begin
				shift_q <= shift_n;
				leds_q <= leds_n;
				ov_q <= (ov_q && !ack) || pop;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_v_s1 <= 1'b0;
		end else if (accept) begin
			tok_v_s1 <= 1'b1;
		end else if (tok_room) begin
			tok_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tok_s1.char_code <= ch;
			tok_s1.char_valid <= (ch != 7'h00);
			tok_s1.special_key <= sk;
			tok_s1.led_state <= leds_n;
			tok_s1.queue_overflow <= push_req && !(ok0 && ok1);
			tok_s1.kind <= kind;
			tok_s1.entry <= '0;
			bank_s1 <= head_q[0];
		end
	end

	always_comb begin
		tok = tok_s1;
		tok.entry = bank_s1 ? od_rd : ev_rd;
	end

	assign tok_valid = tok_v_s1;
	assign init_pend = init_pend_q;
	assign qcount = count_q;

endmodule

[hw/rtl/ksct_back.sv]
// Back part: a short beat queue from the front, keyboard send byte selection
// with the outstanding byte for resends, and the result output register.
// Depends on ksct_pkg.
module ksct_back (
	input  logic              clk,
	input  logic              arst_n,
	input  ksct_pkg::tok_t    tok,
	input  logic              tok_valid,
	output logic              tok_room,
	output logic              result_valid,
	input  logic              result_stall,
	output ksct_pkg::result_t result
);

	localparam int PW = $clog2(ksct_pkg::TOKQ_DEPTH);
	localparam int NW = $clog2(ksct_pkg::TOKQ_DEPTH + 1);

	ksct_pkg::tok_t    tq_q [ksct_pkg::TOKQ_DEPTH];
	logic [PW-1:0]     wr_q;
	logic [PW-1:0]     rd_q;
	logic [NW-1:0]     cnt_q;
	logic [7:0]        outbyte_q;
	ksct_pkg::result_t res_q;
	logic              res_v_q;

	ksct_pkg::tok_t head;
	logic           push;
	logic           pop;
	logic [7:0]     send;
	logic           send_v;
	logic           take;

	assign tok_room = (cnt_q != NW'(ksct_pkg::TOKQ_DEPTH));
	assign push = tok_valid && tok_room;
	assign pop = (cnt_q != '0) && (!res_v_q || !result_stall);
	assign head = tq_q[rd_q];

	always_comb begin
		send = 8'h00;
		send_v = 1'b0;
		take = 1'b0;
		case (head.kind)
			ksct_pkg::SEND_RESEND: begin
				send = outbyte_q;
				send_v = 1'b1;
			end
			ksct_pkg::SEND_POP_RAM: begin
				send = (head.entry == ksct_pkg::ENTRY_ED) ? ksct_pkg::KBD_SET_LEDS
					: {5'b00000, head.entry[2:0]};
				send_v = 1'b1;
				take = 1'b1;
			end
			ksct_pkg::SEND_POP_ED: begin
				send = ksct_pkg::KBD_SET_LEDS;
				send_v = 1'b1;
				take = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
			res_v_q <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(ksct_pkg::TOKQ_DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(ksct_pkg::TOKQ_DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			cnt_q <= cnt_q + NW'(push) - NW'(pop);
			if (pop) begin
				res_v_q <= 1'b1;
			end else if (!result_stall) begin
				res_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			tq_q[wr_q] <= tok;
		end
		if (pop) begin
			res_q.char_code <= head.char_code;
			res_q.char_valid <= head.char_valid;
			res_q.special_key <= head.special_key;
			res_q.kbd_send_byte <= send;
			res_q.kbd_send_valid <= send_v;
			res_q.led_state <= head.led_state;
			res_q.queue_overflow <= head.queue_overflow;
			if (take) begin
				outbyte_q <= send;
			end
		end
	end

	assign result_valid = res_v_q;
	assign result = res_q;

endmodule
